@@ design/w2s_pkg.sv @@
// Package for the world-to-screen projection block: field widths, register
// indexes and shared types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package w2s_pkg;
    localparam int COORD_FRAC_BITS = 16;
    localparam int COEF_FRAC_BITS  = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int DIM_W      = 14;
    localparam int CLIP_W     = 51;   // 32b x 16b products, 4 terms
    localparam int DEN_W      = CLIP_W + 1;
    localparam int NUM_W      = CLIP_W + 1 + DIM_W + COORD_FRAC_BITS;  // 82
    localparam int QUO_W      = 34;   // enough to detect saturation
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ROW0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd5;

    // Classified item passed from front to back
    typedef struct packed {
        logic                     behind;
        logic                     on_screen;
        logic                     neg_x;
        logic                     neg_y;
        logic [NUM_W-1:0]         num_x;
        logic [NUM_W-1:0]         num_y;
        logic [DEN_W-1:0]         den;
    } t_front_item;

    typedef struct packed {
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
        logic               on_screen;
        logic               behind;
    } t_result;
endpackage
`default_nettype wire

@@ design/w2s_if.sv @@
// Valid/ready channel interfaces for world points and screen results.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface w2s_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
    modport source (output valid, world_x, world_y, world_z, input ready);
    modport sink   (input valid, world_x, world_y, world_z, output ready);
endinterface

interface w2s_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic               on_screen;
    logic               behind;
    modport source (output valid, screen_x, screen_y, on_screen, behind, input ready);
    modport sink   (input valid, screen_x, screen_y, on_screen, behind, output ready);
endinterface
`default_nettype wire

@@ design/w2s_front.sv @@
// Front end: matrix transform and classification into divide operands.
// Depends on w2s_pkg.
`timescale 1ns / 1ps
`default_nettype none
module w2s_front (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic signed [31:0]       i_x,
    input  wire logic signed [31:0]       i_y,
    input  wire logic signed [31:0]       i_z,
    input  wire logic [63:0]              i_row [4],
    input  wire logic [w2s_pkg::DIM_W-1:0] i_width,
    input  wire logic [w2s_pkg::DIM_W-1:0] i_height,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output w2s_pkg::t_front_item          o_item
);
    import w2s_pkg::*;

    localparam int PROD_W = 48;
    localparam logic signed [CLIP_W+3:0] W_LIMIT =
        (CLIP_W+4)'(1) <<< (COORD_FRAC_BITS + COEF_FRAC_BITS);

    // stage valids
    logic r_v1, r_v2, r_v3;
    logic en;
    assign en = !o_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_v3;

    // stage 1: sixteen products (translations scaled)
    logic signed [PROD_W-1:0] r_p [4][4];
    logic [DIM_W-1:0] r_w1, r_h1, r_w2, r_h2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid; r_v2 <= r_v1; r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 4; r++) begin
                r_p[r][0] <= PROD_W'(i_x * $signed(i_row[r][15:0]));
                r_p[r][1] <= PROD_W'(i_y * $signed(i_row[r][31:16]));
                r_p[r][2] <= PROD_W'(i_z * $signed(i_row[r][47:32]));
                r_p[r][3] <= PROD_W'($signed(i_row[r][63:48])) <<< COORD_FRAC_BITS;
            end
            r_w1 <= i_width; r_h1 <= i_height;
        end
    end

    // stage 2: row sums give clip coordinates
    logic signed [CLIP_W-1:0] r_c [4];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 4; r++)
                r_c[r] <= CLIP_W'(r_p[r][0]) + CLIP_W'(r_p[r][1])
                        + CLIP_W'(r_p[r][2]) + CLIP_W'(r_p[r][3]);
            r_w2 <= r_w1; r_h2 <= r_h1;
        end
    end

    // stage 3: classify, form numerators for the divider
    logic signed [CLIP_W+1:0] tx, ty;
    logic [CLIP_W:0] mx, my;
    logic signed [CLIP_W+3:0] w10;
    logic in_view;
    always_comb begin
        tx = (CLIP_W+2)'(r_c[0]) + (CLIP_W+2)'(r_c[3]);
        ty = (CLIP_W+2)'(r_c[3]) - (CLIP_W+2)'(r_c[1]);
        mx = tx[CLIP_W+1] ? (CLIP_W+1)'(-tx) : (CLIP_W+1)'(tx);
        my = ty[CLIP_W+1] ? (CLIP_W+1)'(-ty) : (CLIP_W+1)'(ty);
        w10 = ((CLIP_W+4)'(r_c[3]) <<< 3) + ((CLIP_W+4)'(r_c[3]) <<< 1);
        in_view = (r_c[0] >= -r_c[3]) && (r_c[0] <= r_c[3])
               && (r_c[1] >= -r_c[3]) && (r_c[1] <= r_c[3])
               && (r_c[2] >= 0) && (r_c[2] <= r_c[3]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_item.behind    <= w10 < W_LIMIT;
            o_item.on_screen <= in_view && !(w10 < W_LIMIT);
            o_item.neg_x     <= tx[CLIP_W+1];
            o_item.neg_y     <= ty[CLIP_W+1];
            o_item.num_x     <= NUM_W'(mx * r_w2) << COORD_FRAC_BITS;
            o_item.num_y     <= NUM_W'(my * r_h2) << COORD_FRAC_BITS;
            o_item.den       <= DEN_W'(r_c[3]) << 1;
        end
    end
endmodule
`default_nettype wire

@@ design/w2s_queue.sv @@
// Short FIFO decoupling the front end from the divide back end.
// Depends on w2s_pkg.
`timescale 1ns / 1ps
`default_nettype none
module w2s_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire w2s_pkg::t_front_item i_item,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output w2s_pkg::t_front_item      o_item
);
    import w2s_pkg::*;

    t_front_item r_mem [QUEUE_DEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    assign o_ready = r_cnt != 2'(QUEUE_DEPTH);
    assign o_valid = r_cnt != 2'd0;
    assign o_item  = r_mem[r_rp];
    assign push = i_valid && o_ready;
    assign pop  = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_item;
    end
endmodule
`default_nettype wire

@@ design/w2s_back.sv @@
// Back end: pipelined restoring dividers for both axes, saturation and
// output register. Depends on w2s_pkg.
`timescale 1ns / 1ps
`default_nettype none
module w2s_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire w2s_pkg::t_front_item i_item,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output w2s_pkg::t_result          o_res
);
    import w2s_pkg::*;

    // Quotient bits below QB only (QUO_W rounded up to whole stages); any higher bit means saturation.
    // Four quotient bits per stage.
    localparam int BITS_PER = 4;
    localparam int NSTG = (QUO_W + BITS_PER - 1) / BITS_PER;
    localparam int QB = NSTG * BITS_PER;
    localparam int REM_W = DEN_W + 1;

    typedef struct packed {
        logic             behind;
        logic             on_screen;
        logic             neg_x;
        logic             neg_y;
        logic             ovf_x;
        logic             ovf_y;
        logic [NUM_W-1:0] num_x;
        logic [NUM_W-1:0] num_y;
        logic [REM_W-1:0] rem_x;
        logic [REM_W-1:0] rem_y;
        logic [QB-1:0]    q_x;
        logic [QB-1:0]    q_y;
        logic [DEN_W-1:0] den;
    } t_div;

    logic   r_v [NSTG+1];
    t_div   r_s [NSTG+1];
    logic   en;
    logic   r_ov;

    assign en = !r_ov || i_ready;
    assign o_ready = en;
    assign o_valid = r_ov;

    // stage 0: overflow if high numerator part >= den
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= NSTG; s++) r_v[s] <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_valid;
            for (int s = 1; s <= NSTG; s++) r_v[s] <= r_v[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s[0].behind    <= i_item.behind;
            r_s[0].on_screen <= i_item.on_screen;
            r_s[0].neg_x     <= i_item.neg_x;
            r_s[0].neg_y     <= i_item.neg_y;
            r_s[0].ovf_x     <= (i_item.num_x >> QB) >= NUM_W'(i_item.den);
            r_s[0].ovf_y     <= (i_item.num_y >> QB) >= NUM_W'(i_item.den);
            r_s[0].rem_x     <= REM_W'(i_item.num_x >> QB);
            r_s[0].rem_y     <= REM_W'(i_item.num_y >> QB);
            r_s[0].num_x     <= i_item.num_x;
            r_s[0].num_y     <= i_item.num_y;
            r_s[0].q_x       <= '0;
            r_s[0].q_y       <= '0;
            r_s[0].den       <= i_item.den;
        end
    end

    // iterative stages, each resolves BITS_PER quotient bits per axis
    for (genvar g = 0; g < NSTG; g++) begin : g_div
        t_div nxt;
        always_comb begin
            logic [REM_W-1:0] rx, ry;
            nxt = r_s[g];
            rx = r_s[g].rem_x;
            ry = r_s[g].rem_y;
            for (int b = 0; b < BITS_PER; b++) begin
                rx = {rx[REM_W-2:0], r_s[g].num_x[QB-1-g*BITS_PER-b]};
                ry = {ry[REM_W-2:0], r_s[g].num_y[QB-1-g*BITS_PER-b]};
                nxt.q_x[QB-1-g*BITS_PER-b] = rx >= REM_W'(r_s[g].den);
                nxt.q_y[QB-1-g*BITS_PER-b] = ry >= REM_W'(r_s[g].den);
                if (rx >= REM_W'(r_s[g].den)) rx = rx - REM_W'(r_s[g].den);
                if (ry >= REM_W'(r_s[g].den)) ry = ry - REM_W'(r_s[g].den);
            end
            nxt.rem_x = rx;
            nxt.rem_y = ry;
        end
        always_ff @(posedge i_clk) begin
            if (en) r_s[g+1] <= nxt;
        end
    end

    // saturate and sign
    function automatic logic [31:0] sat(input logic neg, input logic ovf,
                                        input logic [QB-1:0] q);
        logic [31:0] res;
        if (neg) begin
            if (ovf || q > QB'(32'h8000_0000)) res = 32'h8000_0000;
            else res = 32'(-q);
        end else begin
            if (ovf || q > QB'(32'h7FFF_FFFF)) res = 32'h7FFF_FFFF;
            else res = q[31:0];
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_v[NSTG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_res.behind    <= r_s[NSTG].behind;
            o_res.on_screen <= r_s[NSTG].on_screen;
            o_res.screen_x  <= r_s[NSTG].behind ? 32'sd0 :
                $signed(sat(r_s[NSTG].neg_x, r_s[NSTG].ovf_x, r_s[NSTG].q_x));
            o_res.screen_y  <= r_s[NSTG].behind ? 32'sd0 :
                $signed(sat(r_s[NSTG].neg_y, r_s[NSTG].ovf_y, r_s[NSTG].q_y));
        end
    end
endmodule
`default_nettype wire

@@ design/world_to_screen_projection.sv @@
// World-to-screen projection top: config registers, front, queue, back.
// Depends on w2s_pkg, w2s_if, w2s_front, w2s_queue, w2s_back.
// Pipeline: front, queue, then back (operand setup, 9 divide stages, output
// register).
// Throughput: one point per cycle while m_out is not back-pressured, set by the pipelined divider stages.
// Reset: synchronous active low; matrix resets to identity, viewport 1920x1080.
`timescale 1ns / 1ps
`default_nettype none
module world_to_screen_projection (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [w2s_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [w2s_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    w2s_in_if.sink                                s_in,
    w2s_out_if.source                             m_out
);
    import w2s_pkg::*;

    logic [63:0]      r_row [4];
    logic [DIM_W-1:0] r_width, r_height;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= 64'd4096;
            r_row[1] <= 64'd268435456;
            r_row[2] <= 64'd17592186044416;
            r_row[3] <= 64'd1152921504606846976;
            r_width  <= DIM_W'(1920);
            r_height <= DIM_W'(1080);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ROW0:   r_row[0] <= i_cfg_data;
                REG_ROW1:   r_row[1] <= i_cfg_data;
                REG_ROW2:   r_row[2] <= i_cfg_data;
                REG_ROW3:   r_row[3] <= i_cfg_data;
                REG_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                REG_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    logic        f_valid, f_ready, q_valid, q_ready;
    t_front_item f_item, q_item;
    t_result     res;

    w2s_front u_front (
        .i_clk, .i_rst_n,
        .i_valid (s_in.valid), .o_ready (s_in.ready),
        .i_x (s_in.world_x), .i_y (s_in.world_y), .i_z (s_in.world_z),
        .i_row (r_row), .i_width (r_width), .i_height (r_height),
        .o_valid (f_valid), .i_ready (f_ready), .o_item (f_item)
    );

    w2s_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid (f_valid), .o_ready (f_ready), .i_item (f_item),
        .o_valid (q_valid), .i_ready (q_ready), .o_item (q_item)
    );

    w2s_back u_back (
        .i_clk, .i_rst_n,
        .i_valid (q_valid), .o_ready (q_ready), .i_item (q_item),
        .o_valid (m_out.valid), .i_ready (m_out.ready), .o_res (res)
    );

    assign m_out.screen_x  = res.screen_x;
    assign m_out.screen_y  = res.screen_y;
    assign m_out.on_screen = res.on_screen;
    assign m_out.behind    = res.behind;
endmodule
`default_nettype wire

@@ dv/world_to_screen_projection_tb.sv @@
// Self-checking testbench for world_to_screen_projection: streams world points
// through valid/ready channels and checks each screen result against a predictor.
// Depends on w2s_pkg, w2s_if and the block under test.
`timescale 1ns / 1ps
module world_to_screen_projection_tb;
    import w2s_pkg::*;

    localparam int ONE_COEF  = 4096;     // 1.0 in Q4.12
    localparam int ONE_COORD = 65536;    // 1.0 in Q16.16
    localparam int SETTLE_CYCLES = 24;   // front + queue + divider + output reg
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct {
        logic signed [31:0] wx;
        logic signed [31:0] wy;
        logic signed [31:0] wz;
    } point_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    w2s_in_if  in_ch ();
    w2s_out_if out_ch ();

    world_to_screen_projection uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_in       (in_ch.sink),
        .m_out      (out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // Predictor copy of the configuration
    logic [63:0] matrix_rows [4];
    logic [13:0] vp_width;
    logic [13:0] vp_height;

    point_t  pending_points [$];
    t_result expected_screen [$];
    point_t  next_point;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      error_count = 0;
    int      in_flight = 0;        // points taken from the queue, result not yet back

    function automatic longint clip_coord(int r, logic signed [31:0] wx,
                                          logic signed [31:0] wy,
                                          logic signed [31:0] wz);
        longint c0, c1, c2, c3;
        c0 = longint'($signed(matrix_rows[r][15:0]));
        c1 = longint'($signed(matrix_rows[r][31:16]));
        c2 = longint'($signed(matrix_rows[r][47:32]));
        c3 = longint'($signed(matrix_rows[r][63:48]));
        return longint'(wx) * c0 + longint'(wy) * c1 + longint'(wz) * c2
             + c3 * longint'(ONE_COORD);
    endfunction

    // dim * t / (2w) in Q16.16, truncated toward zero, saturated to 32 bits
    function automatic logic [31:0] scale_axis(longint t, longint w, logic [13:0] dim);
        logic         neg;
        logic [127:0] mag, num, den, quo;
        neg = (t < 0);
        mag = neg ? 128'(-t) : 128'(t);
        num = mag * (128'(dim) << COORD_FRAC_BITS);
        den = 128'(w) * 2;
        quo = num / den;
        if (neg)
            return (quo > 128'h8000_0000) ? 32'h8000_0000 : -quo[31:0];
        return (quo > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
    endfunction

    function automatic t_result project_point(point_t p);
        t_result r;
        longint  cx, cy, cz, cw;
        cx = clip_coord(0, p.wx, p.wy, p.wz);
        cy = clip_coord(1, p.wx, p.wy, p.wz);
        cz = clip_coord(2, p.wx, p.wy, p.wz);
        cw = clip_coord(3, p.wx, p.wy, p.wz);
        r = '0;
        if (cw * 10 < (longint'(1) << (COORD_FRAC_BITS + COEF_FRAC_BITS))) begin
            r.behind = 1'b1;
            return r;
        end
        r.screen_x  = scale_axis(cx + cw, cw, vp_width);
        r.screen_y  = scale_axis(cw - cy, cw, vp_height);
        r.on_screen = (cx >= -cw && cx <= cw && cy >= -cw && cy <= cw &&
                       cz >= 0 && cz <= cw);
        return r;
    endfunction

    // Initial drive of the input channel and of the output ready
    initial begin
        in_ch.valid   = 1'b0;
        in_ch.world_x = '0;
        in_ch.world_y = '0;
        in_ch.world_z = '0;
        out_ch.ready  = 1'b0;
    end

    // Driver: record each transfer, then present the next queued point
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                next_point.wx = in_ch.world_x;
                next_point.wy = in_ch.world_y;
                next_point.wz = in_ch.world_z;
                expected_screen.push_back(project_point(next_point));
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_points.size() > 0 &&
                        $urandom_range(99) >= send_idle_pct) begin
                    next_point = pending_points.pop_front();
                    in_flight++;
                    in_ch.valid   <= 1'b1;
                    in_ch.world_x <= next_point.wx;
                    in_ch.world_y <= next_point.wy;
                    in_ch.world_z <= next_point.wz;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random backpressure, compare each transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            if (out_ch.valid && out_ch.ready) begin
                in_flight--;
                if (expected_screen.size() == 0) begin
                    $error("unexpected result: x=%0d y=%0d", out_ch.screen_x,
                           out_ch.screen_y);
                    error_count++;
                end else begin
                    want = expected_screen.pop_front();
                    if (out_ch.screen_x !== want.screen_x) begin
                        $error("screen_x: expected %0d, got %0d", want.screen_x,
                               out_ch.screen_x);
                        error_count++;
                    end
                    if (out_ch.screen_y !== want.screen_y) begin
                        $error("screen_y: expected %0d, got %0d", want.screen_y,
                               out_ch.screen_y);
                        error_count++;
                    end
                    if (out_ch.on_screen !== want.on_screen) begin
                        $error("on_screen: expected %0b, got %0b", want.on_screen,
                               out_ch.on_screen);
                        error_count++;
                    end
                    if (out_ch.behind !== want.behind) begin
                        $error("behind: expected %0b, got %0b", want.behind,
                               out_ch.behind);
                        error_count++;
                    end
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_ROW0:   matrix_rows[0] = data;
            REG_ROW1:   matrix_rows[1] = data;
            REG_ROW2:   matrix_rows[2] = data;
            REG_ROW3:   matrix_rows[3] = data;
            REG_WIDTH:  vp_width  = data[13:0];
            REG_HEIGHT: vp_height = data[13:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_point(int wx, int wy, int wz);
        point_t p;
        p.wx = wx;
        p.wy = wy;
        p.wz = wz;
        pending_points.push_back(p);
    endtask

    // Block until every point is sent and every result is back, then settle
    task automatic wait_drained();
        while (pending_points.size() != 0 || in_flight != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [63:0] pack_row(int e0, int e1, int e2, int e3);
        return {16'(e3), 16'(e2), 16'(e1), 16'(e0)};
    endfunction

    function automatic logic [13:0] pick_dim();
        case ($urandom_range(5))
            0: return 14'd0;
            1: return 14'd8192;
            2: return 14'h3FFF;
            default: return 14'($urandom_range(1, 4096));
        endcase
    endfunction

    // Perspective-like matrix so most points land in front and near the frustum
    task automatic load_perspective();
        int sx, sy;
        sx = $urandom_range(ONE_COEF / 2, 2 * ONE_COEF);
        sy = $urandom_range(ONE_COEF / 2, 2 * ONE_COEF);
        write_reg(REG_ROW0, pack_row(sx, $urandom_range(0, 200) - 100, 0,
                                     $urandom_range(0, 2000) - 1000));
        write_reg(REG_ROW1, pack_row(0, sy, $urandom_range(0, 200) - 100,
                                     $urandom_range(0, 2000) - 1000));
        write_reg(REG_ROW2, pack_row(0, 0, $urandom_range(ONE_COEF / 2, ONE_COEF),
                                     -$urandom_range(0, ONE_COEF)));
        write_reg(REG_ROW3, pack_row(0, 0, ONE_COEF, 0));
    endtask

    task automatic queue_random_points(int count, bit frustum);
        int wz, span;
        repeat (count) begin
            if (frustum && $urandom_range(99) < 75) begin
                wz   = $urandom_range(ONE_COORD / 16, 300 * ONE_COORD);
                span = wz + wz / 4;
                add_point($urandom_range(0, 2 * span) - span,
                          $urandom_range(0, 2 * span) - span,
                          ($urandom_range(9) == 0) ? -wz : wz);
            end else begin
                add_point($urandom, $urandom, $urandom);
            end
        end
    endtask

    // Time limit
    initial begin
        #5_000_000;
        $display("world_to_screen_projection_tb failed");
        $finish;
    end

    // Stimulus sequence
    initial begin
        bit frustum;
        matrix_rows[0] = 64'd4096;
        matrix_rows[1] = 64'd268435456;
        matrix_rows[2] = 64'd17592186044416;
        matrix_rows[3] = 64'd1152921504606846976;
        vp_width  = 14'd1920;
        vp_height = 14'd1080;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Identity matrix: view volume edges and field extremes
        add_point(0, 0, 0);
        add_point(ONE_COORD, ONE_COORD, ONE_COORD);
        add_point(-ONE_COORD, -ONE_COORD, 0);
        add_point(ONE_COORD + 1, 0, 0);
        add_point(0, 0, -1);
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_point(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA);
        wait_drained();

        // Perspective divide: behind threshold at w = 0.1, saturation near it
        write_reg(REG_ROW2, pack_row(0, 0, ONE_COEF / 2, 0));
        write_reg(REG_ROW3, pack_row(0, 0, ONE_COEF, 0));
        write_reg(REG_SPARE_A, 64'hFFFF_FFFF_FFFF_FFFF);   // ignored index
        write_reg(REG_SPARE_B, $urandom);
        add_point(0, 0, 0);
        add_point(0, 0, 6553);
        add_point(0, 0, 6554);
        add_point(32'h7FFF_FFFF, 32'h8000_0000, 6554);
        add_point(32'h8000_0000, 32'h7FFF_FFFF, 6554);
        add_point(5 * ONE_COORD, -5 * ONE_COORD, 5 * ONE_COORD);
        add_point(0, 0, -ONE_COORD);
        wait_drained();

        // Viewport extremes: zero size and maximum size
        write_reg(REG_WIDTH, 64'd0);
        write_reg(REG_HEIGHT, 64'h3FFF);
        add_point(ONE_COORD / 2, -ONE_COORD / 2, ONE_COORD);
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, ONE_COORD);
        wait_drained();
        write_reg(REG_WIDTH, 64'h3FFF);
        write_reg(REG_HEIGHT, 64'd0);
        add_point(-ONE_COORD / 3, ONE_COORD / 3, ONE_COORD);
        add_point(32'h8000_0000, 32'h8000_0000, ONE_COORD);
        wait_drained();

        // Random phases cycling through the idle/stall modes
        for (int phase = 0; phase < 12; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            frustum = ($urandom_range(3) != 0);
            if (frustum) begin
                load_perspective();
            end else begin
                write_reg(REG_ROW0, {$urandom, $urandom});
                write_reg(REG_ROW1, {$urandom, $urandom});
                write_reg(REG_ROW2, {$urandom, $urandom});
                write_reg(REG_ROW3, {$urandom, $urandom});
            end
            write_reg(REG_WIDTH, 64'(pick_dim()));
            write_reg(REG_HEIGHT, 64'(pick_dim()));
            queue_random_points(100, frustum);
            wait_drained();
        end

        if (error_count == 0 && expected_screen.size() == 0)
            $display("world_to_screen_projection_tb passed");
        else
            $display("world_to_screen_projection_tb failed");
        $finish;
    end
endmodule
